@@ hdl/sliding_window_rate_estimator_macros.svh @@
// Assertion macros shared by the rate estimator modules.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef SLIDING_WINDOW_RATE_ESTIMATOR_MACROS_SVH
`define SLIDING_WINDOW_RATE_ESTIMATOR_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SWRE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed in the next clock cycle by a consequence.
`define SWRE_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/swre_pkg.sv @@
// Shared constants, register indexes and command types for the rate estimator.
// Depends on nothing; the controller, datapath and top-level files import it.
package swre_pkg;

    localparam int CAPACITY      = 64;
    localparam int INTERVAL_BITS = 32;

    localparam int IN_W     = 32;
    localparam int TPS_W    = 32;
    localparam int WL_W     = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int RATE_W   = 40;
    localparam int FRAC_BITS = 8;
    localparam int USER_W   = 2;

    localparam int DELTA_W  = (INTERVAL_BITS < IN_W) ? INTERVAL_BITS : IN_W;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = DELTA_W + $clog2(CAPACITY);
    localparam int MULT_W   = CNT_W + 1;
    localparam int PROD_W   = MULT_W + TPS_W;
    localparam int NUM_W    = PROD_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [WL_W-1:0]  WL_RESET  = WL_W'(60);
    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000000);
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'b1;

    typedef struct packed {
        logic load_in;
        logic update;
        logic mul;
        logic div_step;
        logic out_load;
    } swre_cmd_t;

    typedef struct packed {
        logic div_last;
    } swre_status_t;

endpackage

@@ hdl/swre_datapath.sv @@
// Datapath of the rate estimator: interval ring, running sum, multiplier,
// serial restoring divider and output register. Depends on swre_pkg and the macros header.
module swre_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swre_pkg::CFG_W-1:0]    cfg_data,
    input  logic [swre_pkg::IN_W-1:0]     in_data,
    input  swre_pkg::swre_cmd_t           cmd,
    output swre_pkg::swre_status_t        status,
    output logic [swre_pkg::RATE_W-1:0]   rate_q8,
    output logic                          zero_sum,
    output logic                          evicted_valid
);
    import swre_pkg::*;
    `include "sliding_window_rate_estimator_macros.svh"

    logic [DELTA_W-1:0]   store_mem [CAPACITY];

    logic [WL_W-1:0]      window_length_reg;
    logic [TPS_W-1:0]     ticks_reg;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [DELTA_W-1:0]   delta_reg;
    logic [DELTA_W-1:0]   old_reg;
    logic                 evict_reg, evict_next;
    logic                 zero_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [RATE_W-1:0]    rate_out_reg;
    logic                 zero_out_reg;
    logic                 evict_out_reg;

    logic [CNT_W-1:0]     len;
    logic                 full;
    logic [MULT_W-1:0]    fill_plus;
    logic [PROD_W-1:0]    product;
    logic [SUM_W:0]       rem_shift;
    logic [SUM_W:0]       sum_ext;
    logic                 rem_ge;
    logic [RATE_W-1:0]    rate_sat;

    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(window_length_reg) > 32'(CAPACITY))
        begin
            len = CNT_W'(CAPACITY);
        end
        else
        begin
            len = CNT_W'(window_length_reg);
        end
    end

    assign full = (fill_reg >= len);

    always_comb
    begin
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        sum_next   = sum_reg;
        evict_next = evict_reg;
        if (cmd.update)
        begin
            if (full)
            begin
                sum_next   = sum_reg + SUM_W'(delta_reg) - SUM_W'(old_reg);
                evict_next = 1'b1;
                if ((CNT_W'(wp_reg) + CNT_W'(1)) >= len)
                begin
                    wp_next = '0;
                end
                else
                begin
                    wp_next = wp_reg + PTR_W'(1);
                end
            end
            else
            begin
                sum_next   = sum_reg + SUM_W'(delta_reg);
                fill_next  = fill_reg + CNT_W'(1);
                evict_next = 1'b0;
            end
        end
    end

    assign fill_plus = MULT_W'(fill_reg) + MULT_W'(1);
    assign product   = PROD_W'(fill_plus) * PROD_W'(ticks_reg);

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign sum_ext   = {1'b0, sum_reg};
    assign rem_ge    = (rem_shift >= sum_ext);

    always_comb
    begin
        if (zero_reg)
        begin
            rate_sat = RATE_MAX;
        end
        else if (quo_reg[NUM_W-1:RATE_W] != '0)
        begin
            rate_sat = RATE_MAX;
        end
        else
        begin
            rate_sat = quo_reg[RATE_W-1:0];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.mul)
        begin
            cnt_next = DIV_CNT_W'(NUM_W - 1);
        end
        else if (cmd.div_step && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
        end
    end

    assign status.div_last = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WL_RESET;
            ticks_reg         <= TPS_RESET;
            fill_reg          <= '0;
            wp_reg            <= '0;
            sum_reg           <= '0;
            cnt_reg           <= '0;
            evict_reg         <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            evict_reg <= evict_next;
            if (cfg_we && (cfg_index == CFG_WINDOW_LENGTH))
            begin
                window_length_reg <= cfg_data[WL_W-1:0];
                fill_reg          <= '0;
                wp_reg            <= '0;
                sum_reg           <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
                wp_reg   <= wp_next;
                sum_reg  <= sum_next;
            end
            if (cfg_we && (cfg_index == CFG_TICKS_PER_SECOND))
            begin
                ticks_reg <= cfg_data[TPS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            delta_reg <= in_data[DELTA_W-1:0];
            old_reg   <= store_mem[wp_reg];
        end
        if (cmd.update)
        begin
            if (full)
            begin
                store_mem[wp_reg] <= delta_reg;
            end
            else
            begin
                store_mem[fill_reg[PTR_W-1:0]] <= delta_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            quo_reg  <= {product, FRAC_BITS'(0)};
            rem_reg  <= '0;
            zero_reg <= (sum_reg == '0);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
            if (rem_ge)
            begin
                rem_reg <= SUM_W'(rem_shift - sum_ext);
            end
            else
            begin
                rem_reg <= rem_shift[SUM_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            rate_out_reg  <= rate_sat;
            zero_out_reg  <= zero_reg;
            evict_out_reg <= evict_reg;
        end
    end

    assign rate_q8       = rate_out_reg;
    assign zero_sum      = zero_out_reg;
    assign evicted_valid = evict_out_reg;

    `SWRE_ASSERT(a_fill_bounded, (fill_reg <= len) || $past(cfg_we), "fill count above window")
    `SWRE_ASSERT_NEXT(a_wp_wraps, cmd.update && full, (CNT_W'(wp_reg) < len), "pointer left window")

endmodule

@@ hdl/swre_ctrl.sv @@
// Controller state machine of the rate estimator: sequences read, update,
// multiply, divide and output handover. Depends on swre_pkg and the macros header.
module swre_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  swre_pkg::swre_status_t status,
    output swre_pkg::swre_cmd_t    cmd
);
    import swre_pkg::*;
    `include "sliding_window_rate_estimator_macros.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_load;

    assign in_ready = (state_reg == S_IDLE);
    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.update   = 1'b0;
        cmd.mul      = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SWRE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken")
    `SWRE_ASSERT_NEXT(a_div_ends, (state_reg == S_DIV) && status.div_last, (state_reg == S_DONE), "divider overran")
    `SWRE_ASSERT(a_out_from_done, !$rose(out_valid_reg) || ($past(state_reg) == S_DONE), "result without division")

endmodule

@@ hdl/sliding_window_rate_estimator.sv @@
// Top level of the sliding-window rate estimator: joins controller and datapath.
// Depends on swre_pkg, swre_ctrl and swre_datapath.
//
//  Channel   Direction  Payload
//  s_*       in         tdata[31:0] interval_ticks
//  m_*       out        tdata[39:0] rate_q8, tuser[0] zero_sum, tuser[1] evicted_valid
//  cfg_*     in         index 0 window_length, index 1 ticks_per_second
//
// Each word passes from acceptance to a loaded result through the ring update, the multiply,
// the serial divider's quotient bits and the output load, in that order.
// The ring is read at the accepting edge, and a new word is taken only once the previous
// result sits in the output register, so no new word is taken while one is in flight.
// A stalled output holds the finished result in the controller's last state until taken.
// Reset is asynchronous and active low; it clears the window and restores register defaults.
module sliding_window_rate_estimator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swre_pkg::IN_W-1:0]      s_tdata,   // interval_ticks
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swre_pkg::RATE_W-1:0]    m_tdata,   // rate_q8
    output logic [swre_pkg::USER_W-1:0]    m_tuser,   // zero_sum, evicted_valid
    input  logic                           cfg_we,
    input  logic [swre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swre_pkg::CFG_W-1:0]     cfg_data
);
    import swre_pkg::*;

    swre_cmd_t    cmd;
    swre_status_t status;
    logic         zero_sum;
    logic         evicted_valid;

    swre_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    swre_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_data       (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .rate_q8       (m_tdata),
        .zero_sum      (zero_sum),
        .evicted_valid (evicted_valid)
    );

    assign m_tuser = {evicted_valid, zero_sum};

endmodule
